// ===== rtl/quaternion_to_roll_pitch_yaw_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for quaternion_to_roll_pitch_yaw
// Shared helpers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROLL_PITCH_YAW_MACROS_SVH
`define QUATERNION_TO_ROLL_PITCH_YAW_MACROS_SVH

// Same-cycle implication, sampled on clk, skipped while dis is high.
`define QRPY_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("qrpy: implication check failed");

// Next-cycle implication, sampled on clk, skipped while dis is high.
`define QRPY_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("qrpy: next-cycle check failed");

`endif

// ===== rtl/qrpy_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrpy_pkg
// Types, constants and helper functions for the quaternion to RPY pipeline.
// ---------------------------------------------------------------------------
package qrpy_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int SQRT_CELLS = 31;          // root bits 30..0
  localparam int LW = 37;                  // CORDIC x/y width
  localparam int ZW = 32;                  // angle accumulator width
  localparam int RW = 62;                  // sqrt remainder/root width
  localparam logic signed [ZW-1:0] DEG180 = 32'sd188743680;  // 180 * 2^20

  typedef struct packed {
    logic signed [LW-1:0] x;
    logic signed [LW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t       roll;
    lane_t       yaw;
    logic        neg;
    logic        clamp;
    logic [29:0] mag;
  } side_t;

  typedef struct packed {
    logic neg;
    logic clamp;
  } ctl_t;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 32'sd47185920;
      5'd1:    r = 32'sd27855475;
      5'd2:    r = 32'sd14718068;
      5'd3:    r = 32'sd7471121;
      5'd4:    r = 32'sd3750058;
      5'd5:    r = 32'sd1876857;
      5'd6:    r = 32'sd938658;
      5'd7:    r = 32'sd469357;
      5'd8:    r = 32'sd234682;
      5'd9:    r = 32'sd117342;
      5'd10:   r = 32'sd58671;
      5'd11:   r = 32'sd29335;
      5'd12:   r = 32'sd14668;
      5'd13:   r = 32'sd7334;
      5'd14:   r = 32'sd3667;
      5'd15:   r = 32'sd1833;
      5'd16:   r = 32'sd917;
      5'd17:   r = 32'sd458;
      5'd18:   r = 32'sd229;
      5'd19:   r = 32'sd115;
      5'd20:   r = 32'sd57;
      5'd21:   r = 32'sd29;
      5'd22:   r = 32'sd14;
      5'd23:   r = 32'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // trial bit 4^k for sqrt cell j (cell 0 handles the top root bit)
  function automatic logic [RW-1:0] sqrt_bit(input int j);
    return {{(RW-1){1'b0}}, 1'b1} << (2 * (SQRT_CELLS - 1 - j));
  endfunction

  // zero detect and half-plane fold ahead of the vectoring stages
  function automatic lane_t cordic_init(input logic signed [LW-1:0] y,
                                        input logic signed [LW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.x = -x;
      l.y = -y;
      l.z = (y >= 0) ? DEG180 : -DEG180;
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

  // round to 7 fraction bits (ties up) and clamp to +-lim
  function automatic logic signed [15:0] to_q7(input logic signed [ZW-1:0] z,
                                               input logic signed [19:0] lim);
    logic signed [ZW:0] s;
    logic signed [19:0] r;
    s = ZW'(1) == 0 ? '0 : ($signed({z[ZW-1], z}) + 33'sd4096);
    r = 20'(s >>> 13);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return 16'(r);
  endfunction

endpackage

// ===== rtl/qrpy_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrpy_sqrt_cell
// One digit of a pipelined integer square root (one root bit per cell).
// ---------------------------------------------------------------------------
module qrpy_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qrpy_pkg::RW-1:0]     bit_in,
  input  logic [qrpy_pkg::RW-1:0]     rem_in,
  input  logic [qrpy_pkg::RW-1:0]     root_in,
  output logic [qrpy_pkg::RW-1:0]     rem_out,
  output logic [qrpy_pkg::RW-1:0]     root_out
);

  logic [qrpy_pkg::RW-1:0] trial;

  assign trial = root_in + bit_in;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= (root_in >> 1) + bit_in;
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in >> 1;
      end
    end
  end

endmodule

// ===== rtl/qrpy_cordic_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrpy_cordic_cell
// One vectoring CORDIC micro-rotation with its angle update.
// ---------------------------------------------------------------------------
module qrpy_cordic_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      stage,
  input  qrpy_pkg::lane_t lane_in,
  output qrpy_pkg::lane_t lane_out
);

  logic signed [qrpy_pkg::LW-1:0] dx;
  logic signed [qrpy_pkg::LW-1:0] dy;
  logic signed [qrpy_pkg::ZW-1:0] da;

  assign dx = lane_in.y >>> stage;
  assign dy = lane_in.x >>> stage;
  assign da = qrpy_pkg::atan_tab(stage);

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.zero <= lane_in.zero;
      if (lane_in.y > 0) begin
        lane_out.x <= lane_in.x + dx;
        lane_out.y <= lane_in.y - dy;
        lane_out.z <= lane_in.z + da;
      end else begin
        lane_out.x <= lane_in.x - dx;
        lane_out.y <= lane_in.y + dy;
        lane_out.z <= lane_in.z - da;
      end
    end
  end

endmodule

// ===== rtl/quaternion_to_roll_pitch_yaw.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_to_roll_pitch_yaw
// Unit quaternion (Q1.15) to roll, pitch, yaw in degrees (Q.7), pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel quat_*: one request carries x, y, z, w. Taken on a clock
//   edge with quat_valid high and quat_stall low.
//   Output channel angle_*: one result per request, in request order, taken
//   on an edge with angle_valid high and angle_stall low.
//   Throughput: one request per cycle while angle_stall does not hold the pipe.
//   Steps, in order: product, sum, pitch-magnitude stages, the 30x30 square,
//   one square-root cell per root bit, CORDIC init, one CORDIC cell per stage
//   (16 CORDIC stages), rounding.
//   The 31-cell square-root chain for the pitch cosine sets the latency;
//   roll and yaw ride a delay line next to it.
//   The whole pipe moves on one enable: it holds only when the final result
//   register is full and angle_stall is high, and quat_stall mirrors that.
//   Reset (rst, synchronous) clears all valid bits; data regs are not reset.
// ---------------------------------------------------------------------------
module quaternion_to_roll_pitch_yaw (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               angle_valid,
  input  logic               angle_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);

  localparam int CS   = qrpy_pkg::CS;
  localparam int SQ   = qrpy_pkg::SQRT_CELLS;
  localparam int LW   = qrpy_pkg::LW;
  localparam int RW   = qrpy_pkg::RW;
  localparam int NPIPE = 3 + 1 + SQ + 1 + CS + 1;

  logic             en;
  logic [NPIPE-1:0] vld;

  assign en          = !(vld[NPIPE-1] && angle_stall);
  assign quat_stall  = !en;
  assign angle_valid = vld[NPIPE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NPIPE-2:0], quat_valid};
    end
  end

  // stage 1: the nine products, exact
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // stage 2: sines and cosines, 30 fraction bits
  localparam logic signed [33:0] ONE = 34'sd1 <<< 30;
  logic signed [33:0] s_r, c_r, s_p, s_y, c_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= (34'(p_wx) + 34'(p_yz)) <<< 1;
      c_r <= ONE - ((34'(p_xx) + 34'(p_yy)) <<< 1);
      s_p <= (34'(p_wy) - 34'(p_zx)) <<< 1;
      s_y <= (34'(p_wz) + 34'(p_xy)) <<< 1;
      c_y <= ONE - ((34'(p_yy) + 34'(p_zz)) <<< 1);
    end
  end

  // stage 3: roll/yaw init, pitch saturation and magnitude
  // side[0] is stage 3, side[1] stage 4, side[j+2] rides with sqrt cell j
  qrpy_pkg::side_t side [SQ+2];
  qrpy_pkg::side_t side_next;
  logic signed [33:0] sp_abs;

  always_comb begin
    sp_abs          = s_p[33] ? -s_p : s_p;
    side_next.roll  = qrpy_pkg::cordic_init(LW'(s_r), LW'(c_r));
    side_next.yaw   = qrpy_pkg::cordic_init(LW'(s_y), LW'(c_y));
    side_next.neg   = s_p[33];
    side_next.clamp = (s_p >= ONE) || (s_p <= -ONE);
    side_next.mag   = sp_abs[29:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_next;
    end
  end

  // stage 4: radicand 2^60 - s^2
  logic [RW-1:0] rad;

  always_ff @(posedge clk) begin
    if (en) begin
      rad     <= (RW'(1) << 60) - RW'(60'(side[0].mag) * 60'(side[0].mag));
      side[1] <= side[0];
    end
  end

  // square-root chain: one root bit per cell
  logic [RW-1:0] rem_c  [SQ+1];
  logic [RW-1:0] root_c [SQ+1];

  assign rem_c[0]  = rad;
  assign root_c[0] = '0;

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    qrpy_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .bit_in   (qrpy_pkg::sqrt_bit(j)),
      .rem_in   (rem_c[j]),
      .root_in  (root_c[j]),
      .rem_out  (rem_c[j+1]),
      .root_out (root_c[j+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        side[j+2] <= side[j+1];
      end
    end
  end

  // CORDIC init stage: three lanes; the pitch cosine is never negative
  qrpy_pkg::lane_t lr [CS+1];
  qrpy_pkg::lane_t lp [CS+1];
  qrpy_pkg::lane_t ly [CS+1];
  qrpy_pkg::ctl_t  ctl [CS+1];
  logic signed [LW-1:0] p_sin;

  assign p_sin = side[SQ+1].neg ? -$signed({7'b0, side[SQ+1].mag})
                                :  $signed({7'b0, side[SQ+1].mag});

  always_ff @(posedge clk) begin
    if (en) begin
      lr[0]        <= side[SQ+1].roll;
      ly[0]        <= side[SQ+1].yaw;
      lp[0]        <= qrpy_pkg::cordic_init(p_sin, $signed(LW'(root_c[SQ][30:0])));
      ctl[0].neg   <= side[SQ+1].neg;
      ctl[0].clamp <= side[SQ+1].clamp;
    end
  end

  for (genvar j = 0; j < CS; j++) begin : g_cordic
    qrpy_cordic_cell u_roll (
      .clk (clk), .en (en), .stage (5'(j)), .lane_in (lr[j]), .lane_out (lr[j+1])
    );
    qrpy_cordic_cell u_pitch (
      .clk (clk), .en (en), .stage (5'(j)), .lane_in (lp[j]), .lane_out (lp[j+1])
    );
    qrpy_cordic_cell u_yaw (
      .clk (clk), .en (en), .stage (5'(j)), .lane_in (ly[j]), .lane_out (ly[j+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        ctl[j+1] <= ctl[j];
      end
    end
  end

  // output stage: zero case, rounding, clamps, pitch saturation
  logic signed [15:0] pitch_q7;

  assign pitch_q7 = qrpy_pkg::to_q7(lp[CS].zero ? '0 : lp[CS].z, 20'sd11520);

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle    <= qrpy_pkg::to_q7(lr[CS].zero ? '0 : lr[CS].z, 20'sd23040);
      yaw_angle     <= qrpy_pkg::to_q7(ly[CS].zero ? '0 : ly[CS].z, 20'sd23040);
      pitch_clamped <= ctl[CS].clamp;
      if (ctl[CS].clamp) begin
        pitch_angle <= ctl[CS].neg ? -15'sd11520 : 15'sd11520;
      end else begin
        pitch_angle <= 15'(pitch_q7);
      end
    end
  end

endmodule

// ===== rtl/qrpy_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrpy_checker
// Port-level checks for quaternion_to_roll_pitch_yaw, bound to the top.
// ---------------------------------------------------------------------------
`include "quaternion_to_roll_pitch_yaw_macros.svh"

module qrpy_checker (
  input logic               clk,
  input logic               rst,
  input logic               quat_valid,
  input logic               quat_stall,
  input logic               angle_valid,
  input logic               angle_stall,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle,
  input logic               pitch_clamped
);

  logic        out_held;
  logic        pitch_is_90;
  logic        in_range;
  logic [47:0] angles;

  assign out_held    = angle_valid && angle_stall;
  assign pitch_is_90 = (pitch_angle == 15'sd11520) || (pitch_angle == -15'sd11520);
  assign in_range    = (roll_angle <= 16'sd23040) && (roll_angle >= -16'sd23040) &&
                       (yaw_angle <= 16'sd23040) && (yaw_angle >= -16'sd23040);
  assign angles      = {roll_angle, pitch_angle, yaw_angle, pitch_clamped};

  `QRPY_ASSERT_IMP(a_clamp_is_90, clk, rst, angle_valid && pitch_clamped, pitch_is_90)

  `QRPY_ASSERT_IMP(a_roll_yaw_range, clk, rst, angle_valid, in_range)

  `QRPY_ASSERT_IMP(a_backpressure, clk, rst, out_held, quat_stall)

  `QRPY_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !angle_valid && !quat_stall)

  `QRPY_ASSERT_NEXT(a_hold_result, clk, rst, out_held, angle_valid && $stable(angles))

endmodule

bind quaternion_to_roll_pitch_yaw qrpy_checker u_qrpy_checker (
  .clk           (clk),
  .rst           (rst),
  .quat_valid    (quat_valid),
  .quat_stall    (quat_stall),
  .angle_valid   (angle_valid),
  .angle_stall   (angle_stall),
  .roll_angle    (roll_angle),
  .pitch_angle   (pitch_angle),
  .yaw_angle     (yaw_angle),
  .pitch_clamped (pitch_clamped)
);
